>>> rtl/csa_pkg.sv
package csa_pkg;

   localparam int GRID_DIM_DEFAULT  = 32;
   localparam int ACC_WIDTH_DEFAULT = 40;

   localparam int SAMPLE_W = 32;
   localparam int INDEX_W  = 5;
   localparam int CELL_W   = 40;
   localparam int OP_W     = 2;

   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_CLEAR  = 2'd0;
   localparam op_type OP_ACCUM  = 2'd1;
   localparam op_type OP_READ   = 2'd2;
   localparam op_type OP_UNUSED = 2'd3;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;       // capture the word and launch the memory reads
      logic read_sel;   // address the reads from read_row/read_col
      logic write;      // write back the saturated sum
      logic clear;      // drop every row valid bit
      logic out_load;   // move the read result into the output register
   } cmd_type;

endpackage

>>> rtl/csa_ctrl.sv
module csa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  csa_pkg::op_type    req_op,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output csa_pkg::cmd_type   cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      is_read_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.load     = accept && ((req_op == csa_pkg::OP_ACCUM) || (req_op == csa_pkg::OP_READ));
      cmd.read_sel = (req_op == csa_pkg::OP_READ);
      cmd.clear    = accept && (req_op == csa_pkg::OP_CLEAR);
      cmd.write    = (state_ff == ST_EXEC) && !is_read_ff;
      cmd.out_load = (state_ff == ST_EXEC) && is_read_ff && out_free;
   end

   // Raise valid with a new result, drop it once the pending one is taken
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         is_read_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.load) begin
                  is_read_ff <= cmd.read_sel;
                  state_ff   <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (!is_read_ff || out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

>>> rtl/csa_datapath.sv
module csa_datapath #(
   parameter int GRID_DIM  = csa_pkg::GRID_DIM_DEFAULT,
   parameter int ACC_WIDTH = csa_pkg::ACC_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  csa_pkg::cmd_type                    cmd,
   input  logic                                mode_we,
   input  logic                                mode_data,
   input  logic signed [csa_pkg::SAMPLE_W-1:0] sample_value,
   input  logic                                negate,
   input  logic [csa_pkg::INDEX_W-1:0]         bucket,
   input  logic [csa_pkg::INDEX_W-1:0]         position,
   input  logic [csa_pkg::INDEX_W-1:0]         read_row,
   input  logic [csa_pkg::INDEX_W-1:0]         read_col,
   output logic [csa_pkg::CELL_W-1:0]          cell_value
);

   localparam int ROW_BITS = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
   localparam int ROWS     = 1 << ROW_BITS;
   localparam int ADDR_W   = 2 * ROW_BITS;
   localparam int CELLS    = 1 << ADDR_W;
   localparam int SW       = csa_pkg::SAMPLE_W;

   localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

   logic signed [ACC_WIDTH-1:0] sketch_mem_ff [CELLS];
   logic [ROWS-1:0]             touched_mem_ff [ROWS];
   logic [ROWS-1:0]             row_valid_ff;
   logic                        mode_ff;

   logic [csa_pkg::INDEX_W-1:0] row_sel;
   logic [csa_pkg::INDEX_W-1:0] col_sel;
   logic [ROW_BITS-1:0]         row_in;
   logic [ROW_BITS-1:0]         col_in;
   logic                        in_range_in;

   logic [ROW_BITS-1:0]         row_ff;
   logic [ROW_BITS-1:0]         col_ff;
   logic                        in_range_ff;
   logic signed [SW-1:0]        sample_ff;
   logic                        negate_ff;
   logic signed [ACC_WIDTH-1:0] value_rd_ff;
   logic [ROWS-1:0]             touched_rd_ff;
   logic [csa_pkg::CELL_W-1:0]  cell_value_ff;

   logic [ROWS-1:0]             touched_row;
   logic                        hit;
   logic signed [ACC_WIDTH-1:0] old_value;
   logic signed [SW:0]          sample_ext;
   logic signed [SW:0]          addend;
   logic signed [ACC_WIDTH:0]   sum;
   logic signed [ACC_WIDTH-1:0] sat_in;

   // Pick the cell: a read names it directly, an accumulate maps through the mode
   always_comb begin
      if (cmd.read_sel) begin
         row_sel = read_row;
         col_sel = read_col;
      end else if (mode_ff) begin
         row_sel = position;
         col_sel = bucket;
      end else begin
         row_sel = bucket;
         col_sel = position;
      end
      row_in      = ROW_BITS'(row_sel);
      col_in      = ROW_BITS'(col_sel);
      in_range_in = (int'(row_sel) < GRID_DIM) && (int'(col_sel) < GRID_DIM);
   end

   assign touched_row = row_valid_ff[row_ff] ? touched_rd_ff : '0;
   assign hit         = in_range_ff && touched_row[col_ff];
   assign old_value   = hit ? value_rd_ff : '0;
   assign sample_ext  = {sample_ff[SW-1], sample_ff};
   assign addend      = negate_ff ? -sample_ext : sample_ext;
   assign sum         = {old_value[ACC_WIDTH-1], old_value} + (ACC_WIDTH+1)'(addend);

   always_comb begin
      if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
         sat_in = sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
      end else begin
         sat_in = sum[ACC_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         if (mode_we) begin
            mode_ff <= mode_data;
         end
         if (cmd.clear) begin
            row_valid_ff <= '0;
         end else if (cmd.write && in_range_ff) begin
            row_valid_ff[row_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         row_ff        <= row_in;
         col_ff        <= col_in;
         in_range_ff   <= in_range_in;
         sample_ff     <= sample_value;
         negate_ff     <= negate;
         value_rd_ff   <= sketch_mem_ff[{row_in, col_in}];
         touched_rd_ff <= touched_mem_ff[row_in];
      end
      if (cmd.write && in_range_ff) begin
         sketch_mem_ff[{row_ff, col_ff}] <= sat_in;
         touched_mem_ff[row_ff]          <= touched_row | (ROWS'(1) << col_ff);
      end
      if (cmd.out_load) begin
         cell_value_ff <= csa_pkg::CELL_W'(old_value);
      end
   end

   assign cell_value = cell_value_ff;

endmodule

>>> rtl/count_sketch_accumulator.sv
// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  tuser: op; tdata: value, negate, bucket, position, row, col
// rsp       out  rsp_tvalid/rsp_tready  tdata: cell_value
// csr       in   csr_valid/csr_ready    csr_data: sketch_mode
//
// A clear word is done when it is accepted; an accumulate or read word goes on to the execute
// state: the registered read of the sketch memory sits between address and read-modify-write.
// Clear drops one valid bit per grid row at once; row touched masks live in
// a small memory and are ignored while their row bit is down, so no clearing pass runs.
// Synchronous reset clears the controller, the row valid bits and sketch_mode.
// A read word holds in the execute state while the previous result waits on rsp_tready;
// the output register lets the next word enter while a result is still pending.
module count_sketch_accumulator #(
   parameter int GRID_DIM  = csa_pkg::GRID_DIM_DEFAULT,
   parameter int ACC_WIDTH = csa_pkg::ACC_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] sample_value, [32] negate, [37:33] bucket, [42:38] position,
   // [47:43] read_row, [52:48] read_col, [55:53] zero
   input  logic [55:0] req_tdata,
   // [1:0] op
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [39:0] cell_value
   output logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   csa_pkg::cmd_type cmd;

   // Configuration is always taken; the user writes it only while the block is idle; not enforced
   assign csr_ready = 1'b1;

   csa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   csa_datapath #(
      .GRID_DIM  (GRID_DIM),
      .ACC_WIDTH (ACC_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .mode_we      (csr_valid),
      .mode_data    (csr_data),
      .sample_value (req_tdata[31:0]),
      .negate       (req_tdata[32]),
      .bucket       (req_tdata[37:33]),
      .position     (req_tdata[42:38]),
      .read_row     (req_tdata[47:43]),
      .read_col     (req_tdata[52:48]),
      .cell_value   (rsp_tdata)
   );

endmodule

>>> bench/count_sketch_accumulator_checker.sv
module count_sketch_accumulator_checker #(
   parameter int GRID_DIM  = csa_pkg::GRID_DIM_DEFAULT,
   parameter int ACC_WIDTH = csa_pkg::ACC_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [55:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_data,
   output int          fail_count,
   output int          results_pending,
   output int          results_checked
);

   typedef struct {
      logic [csa_pkg::CELL_W-1:0]  cell_value;
      logic [csa_pkg::INDEX_W-1:0] row;
      logic [csa_pkg::INDEX_W-1:0] col;
   } cell_read_type;

   cell_read_type               expected_cells[$];
   logic signed [ACC_WIDTH-1:0] cell_sum [GRID_DIM*GRID_DIM];
   bit                          cell_live [GRID_DIM*GRID_DIM];
   bit                          column_mode;

   // Exact add, then clamp to the accumulator rails
   function automatic logic signed [ACC_WIDTH-1:0] saturating_add(
      logic signed [ACC_WIDTH-1:0] acc, longint delta);
      longint hi;
      longint lo;
      longint total;
      hi = (longint'(1) <<< (ACC_WIDTH - 1)) - 1;
      lo = -hi - 1;
      total = longint'(acc) + delta;
      if (total > hi) begin
         total = hi;
      end else if (total < lo) begin
         total = lo;
      end
      return ACC_WIDTH'(total);
   endfunction

   task automatic note_failure(string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   task automatic take_result();
      cell_read_type want;
      if (expected_cells.size() == 0) begin
         note_failure($sformatf("unexpected result %h with no read outstanding", rsp_tdata));
         return;
      end
      want = expected_cells.pop_front();
      results_checked++;
      if (rsp_tdata !== want.cell_value) begin
         note_failure($sformatf("read of cell (%0d,%0d): expected %h, got %h",
                                want.row, want.col, want.cell_value, rsp_tdata));
      end
   endtask

   task automatic apply_word();
      csa_pkg::op_type             op;
      logic [31:0]                 sample;
      bit                          neg;
      logic [csa_pkg::INDEX_W-1:0] bucket;
      logic [csa_pkg::INDEX_W-1:0] position;
      logic [csa_pkg::INDEX_W-1:0] read_row;
      logic [csa_pkg::INDEX_W-1:0] read_col;
      int                          row;
      int                          col;
      int                          idx;
      longint                      delta;
      cell_read_type               want;
      op       = req_tuser;
      sample   = req_tdata[31:0];
      neg      = req_tdata[32];
      bucket   = req_tdata[37:33];
      position = req_tdata[42:38];
      read_row = req_tdata[47:43];
      read_col = req_tdata[52:48];
      case (op)
         csa_pkg::OP_CLEAR: begin
            foreach (cell_live[i]) cell_live[i] = 1'b0;
         end
         csa_pkg::OP_ACCUM: begin
            row = int'(column_mode ? position : bucket);
            col = int'(column_mode ? bucket : position);
            if (row < GRID_DIM && col < GRID_DIM) begin
               idx   = row * GRID_DIM + col;
               delta = longint'($signed(sample));
               if (neg) delta = -delta;
               cell_sum[idx]  = saturating_add(cell_live[idx] ? cell_sum[idx] : '0, delta);
               cell_live[idx] = 1'b1;
            end
         end
         csa_pkg::OP_READ: begin
            want.cell_value = '0;
            want.row        = read_row;
            want.col        = read_col;
            if (int'(read_row) < GRID_DIM && int'(read_col) < GRID_DIM) begin
               idx = int'(read_row) * GRID_DIM + int'(read_col);
               if (cell_live[idx]) want.cell_value = csa_pkg::CELL_W'(cell_sum[idx]);
            end
            expected_cells.push_back(want);
         end
         default: begin
         end
      endcase
   endtask

   // A result leaving at the same edge as a new word belongs to an older word,
   // so check it before predicting
   always @(posedge clock) begin
      if (reset) begin
         foreach (cell_live[i]) cell_live[i] = 1'b0;
         column_mode = 1'b0;
         expected_cells.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) take_result();
         if (csr_valid && csr_ready) column_mode = csr_data;
         if (req_tvalid && req_tready) apply_word();
      end
      results_pending = expected_cells.size();
   end

endmodule

>>> bench/count_sketch_accumulator_tb.sv
module count_sketch_accumulator_tb;

   // Cycles with no handshake at all before the run is declared hung
   localparam int WATCHDOG_LIMIT = 2000;
   // Accumulate words leave no result; let the pipeline settle before a mode write
   localparam int DRAIN_HOLD     = 4;
   localparam int END_HOLD       = 8;
   localparam int RANDOM_WORDS   = 96;
   // Enough near-full-scale accumulates to cross a rail from an untouched cell
   localparam int BURST_WORDS    = 272;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [31:0] sample_value, [32] negate, [37:33] bucket, [42:38] position,
   // [47:43] read_row, [52:48] read_col, [55:53] zero
   logic [55:0] req_tdata  = '0;
   // [1:0] op
   logic [1:0]  req_tuser  = csa_pkg::OP_CLEAR;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [39:0] cell_value
   logic [39:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_data   = 1'b0;

   int fail_count;
   int results_pending;
   int results_checked;

   // Both sides stop idling while this is set
   bit steady = 1'b0;
   bit sketch_mode_now = 1'b0;
   int quiet_cycles = 0;
   int accum_words  = 0;
   int read_words   = 0;
   int clear_words  = 0;
   int unused_words = 0;
   int mode_writes  = 0;

   always #2 clock = ~clock;

   count_sketch_accumulator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   count_sketch_accumulator_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .results_pending (results_pending),
      .results_checked (results_checked)
   );

   // Receiver: drop ready about 15 percent of the time unless the steady stretch is on
   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 15);
   end

   // Watchdog: count cycles in which no channel moves a word
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no handshake for %0d cycles, %0d results outstanding",
                     quiet_cycles, results_pending);
            $display("[count_sketch_accumulator] ERROR");
            $finish;
         end
      end
   end

   // Entered and left at a falling edge. Hold the word until the block takes it.
   task automatic send_word(csa_pkg::op_type op, logic [31:0] value, bit neg,
                            logic [4:0] bucket, logic [4:0] position,
                            logic [4:0] read_row, logic [4:0] read_col);
      if (!steady && $urandom_range(0, 99) < 15) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, read_col, read_row, position, bucket, neg, value};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      case (op)
         csa_pkg::OP_CLEAR: clear_words++;
         csa_pkg::OP_ACCUM: accum_words++;
         csa_pkg::OP_READ:  read_words++;
         default:           unused_words++;
      endcase
   endtask

   // Stop sending and wait until every outstanding read has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (DRAIN_HOLD) @(negedge clock);
   endtask

   // Only called with the block idle
   task automatic write_mode(bit mode);
      csr_valid <= 1'b1;
      csr_data  <= mode;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      sketch_mode_now = mode;
      mode_writes++;
   endtask

   // Mostly a few hot indexes at both ends so reads land on live cells
   function automatic logic [4:0] pick_index();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) return 5'($urandom_range(0, 3));
      if (roll < 70) return 5'($urandom_range(28, 31));
      return 5'($urandom);
   endfunction

   function automatic logic [31:0] pick_sample();
      case ($urandom_range(0, 19))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_word();
      int roll;
      // Pressure: now and then let every outstanding read drain first
      if ($urandom_range(0, 99) < 2) drain_results();
      roll = $urandom_range(0, 99);
      if (roll < 58) begin
         send_word(csa_pkg::OP_ACCUM, pick_sample(), 1'($urandom), pick_index(),
                   pick_index(), 5'($urandom), 5'($urandom));
      end else if (roll < 92) begin
         send_word(csa_pkg::OP_READ, $urandom, 1'($urandom), 5'($urandom), 5'($urandom),
                   pick_index(), pick_index());
      end else if (roll < 96) begin
         send_word(csa_pkg::OP_UNUSED, $urandom, 1'($urandom), 5'($urandom), 5'($urandom),
                   5'($urandom), 5'($urandom));
      end else begin
         send_word(csa_pkg::OP_CLEAR, $urandom, 1'($urandom), 5'($urandom), 5'($urandom),
                   5'($urandom), 5'($urandom));
      end
   endtask

   // Drive one cell into a rail with near-full-scale words of one direction,
   // flipping negate at random, and read it back along the way
   task automatic saturation_burst(bit upward, logic [4:0] bucket, logic [4:0] position);
      logic [31:0] mag;
      bit          neg;
      logic [4:0]  read_row;
      logic [4:0]  read_col;
      read_row = sketch_mode_now ? position : bucket;
      read_col = sketch_mode_now ? bucket : position;
      for (int i = 0; i < BURST_WORDS; i++) begin
         if (i % 32 == 31) begin
            send_word(csa_pkg::OP_READ, $urandom, 1'($urandom), 5'($urandom), 5'($urandom),
                      read_row, read_col);
         end else begin
            mag = $urandom_range(32'h7F00_0000, 32'h7FFF_FFFF);
            neg = 1'($urandom);
            send_word(csa_pkg::OP_ACCUM, (neg ^ upward) ? mag : -mag, neg, bucket, position,
                      5'($urandom), 5'($urandom));
         end
      end
   endtask

   initial begin
      // Hold reset while the clock starts, then release it for good
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Row mode after reset: untouched cell, field extremes, sign handling
      send_word(csa_pkg::OP_READ,   32'h0,         1'b0, 5'd0,  5'd0,  5'd0,  5'd0);
      send_word(csa_pkg::OP_ACCUM,  32'h7FFF_FFFF, 1'b0, 5'd31, 5'd0,  5'd0,  5'd0);
      send_word(csa_pkg::OP_ACCUM,  32'h8000_0000, 1'b1, 5'd31, 5'd0,  5'd31, 5'd31);
      send_word(csa_pkg::OP_READ,   32'h0,         1'b0, 5'd0,  5'd0,  5'd31, 5'd0);
      send_word(csa_pkg::OP_ACCUM,  32'h8000_0000, 1'b0, 5'd0,  5'd31, 5'd0,  5'd0);
      send_word(csa_pkg::OP_ACCUM,  32'hFFFF_FFFF, 1'b1, 5'd0,  5'd31, 5'd0,  5'd0);
      send_word(csa_pkg::OP_READ,   32'hFFFF_FFFF, 1'b1, 5'd31, 5'd31, 5'd0,  5'd31);
      // Unused op code with every data bit set: no effect, no result
      send_word(csa_pkg::OP_UNUSED, 32'hFFFF_FFFF, 1'b1, 5'd31, 5'd31, 5'd31, 5'd31);
      send_word(csa_pkg::OP_READ,   32'h0,         1'b0, 5'd0,  5'd0,  5'd31, 5'd31);
      send_word(csa_pkg::OP_CLEAR,  32'h0,         1'b0, 5'd0,  5'd0,  5'd0,  5'd0);
      send_word(csa_pkg::OP_READ,   32'h0,         1'b0, 5'd0,  5'd0,  5'd31, 5'd0);
      // After a clear an accumulate starts from zero
      send_word(csa_pkg::OP_ACCUM,  32'hFFFF_FFFB, 1'b0, 5'd31, 5'd0,  5'd0,  5'd0);
      send_word(csa_pkg::OP_READ,   32'h0,         1'b0, 5'd0,  5'd0,  5'd31, 5'd0);
      send_word(csa_pkg::OP_READ,   32'h0,         1'b0, 5'd0,  5'd0,  5'd0,  5'd31);

      // Column mode keeps the grid; bucket now picks the column
      drain_results();
      write_mode(1'b1);
      send_word(csa_pkg::OP_ACCUM,  32'h1234_5678, 1'b0, 5'd3,  5'd7,  5'd0,  5'd0);
      send_word(csa_pkg::OP_READ,   32'h0,         1'b0, 5'd0,  5'd0,  5'd7,  5'd3);
      send_word(csa_pkg::OP_READ,   32'h0,         1'b0, 5'd0,  5'd0,  5'd3,  5'd7);
      send_word(csa_pkg::OP_ACCUM,  32'h0,         1'b1, 5'd31, 5'd31, 5'd0,  5'd0);
      send_word(csa_pkg::OP_READ,   32'h0,         1'b0, 5'd0,  5'd0,  5'd31, 5'd31);
      send_word(csa_pkg::OP_ACCUM,  32'h0000_0001, 1'b0, 5'd31, 5'd0,  5'd0,  5'd0);
      send_word(csa_pkg::OP_READ,   32'h0,         1'b0, 5'd0,  5'd0,  5'd0,  5'd31);
      send_word(csa_pkg::OP_READ,   32'h0,         1'b0, 5'd0,  5'd0,  5'd31, 5'd0);

      // Row mode: push one cell into the upper rail, then mixed traffic
      drain_results();
      write_mode(1'b0);
      saturation_burst(1'b1, 5'd5, 5'd9);
      for (int i = 0; i < RANDOM_WORDS / 4; i++) random_word();

      // Column mode with no idling on either side: lower rail, mixed traffic
      drain_results();
      write_mode(1'b1);
      steady = 1'b1;
      saturation_burst(1'b0, 5'd12, 5'd20);
      for (int i = 0; i < RANDOM_WORDS / 4; i++) random_word();
      steady = 1'b0;

      // Rewrite the same mode, then return to row mode on the same grid
      drain_results();
      write_mode(1'b1);
      for (int i = 0; i < RANDOM_WORDS / 4; i++) random_word();
      drain_results();
      write_mode(1'b0);
      for (int i = 0; i < RANDOM_WORDS - 3 * (RANDOM_WORDS / 4); i++) random_word();

      // Wait out every outstanding read, then a little longer for strays
      req_tvalid <= 1'b0;
      while (results_pending != 0) @(negedge clock);
      repeat (END_HOLD) @(negedge clock);

      $display("covered %0d accumulates, %0d reads, %0d clears, %0d unused-op words",
               accum_words, read_words, clear_words, unused_words);
      $display("over %0d sketch mode writes with both rails reached; %0d results compared",
               mode_writes, results_checked);
      if (fail_count == 0 && results_pending == 0) begin
         $display("[count_sketch_accumulator] OK");
      end else begin
         $display("%0d failures, %0d results outstanding", fail_count, results_pending);
         $display("[count_sketch_accumulator] ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/csa_pkg.sv
rtl/csa_ctrl.sv
rtl/csa_datapath.sv
rtl/count_sketch_accumulator.sv
bench/count_sketch_accumulator_checker.sv
bench/count_sketch_accumulator_tb.sv
